### rtl/euler_to_quaternion_defines.svh
// Assertion macros for the Euler angle to quaternion block.
// Used by the top level only; depends on a clk and rst_n in scope.
`ifndef EULER_TO_QUATERNION_DEFINES_SVH
`define EULER_TO_QUATERNION_DEFINES_SVH

// Same-cycle implication checked on every clock outside reset.
`define E2Q_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequence is checked a fixed number of cycles later.
`define E2Q_ASSERT_DLY(label, ante, dly, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

### rtl/e2q_pkg.sv
// Package for the Euler angle to quaternion block: widths, item types,
// pipeline depths and the CORDIC constant functions. No dependencies.
`default_nettype none

package e2q_pkg;

    localparam int ANGLE_BITS = 16;
    localparam int FRAC_BITS  = 14;

    // Width of a sine, cosine or quaternion component (covers +/- 2^FRAC_BITS).
    localparam int QW = FRAC_BITS + 2;

    // CORDIC datapath: two integer bits, CF fraction bits.
    localparam int CF   = 46;
    localparam int CW   = CF + 2;
    localparam int NSTG = 44;

    // Residual angle: guard bits below the input angle LSB, plus a sign bit.
    localparam int ZG = 32;
    localparam int ZW = ANGLE_BITS + ZG + 1;

    // Sine/cosine latency: prep stage, rotation stages, rounding stage.
    localparam int SC_LAT = NSTG + 2;
    // Whole block: two multiply stages and the rounding stage follow.
    localparam int LAT = SC_LAT + 3;

    localparam real PI_R = 3.14159265358979323846;

    // Radians to residual angle units of pi / 2^(ANGLE_BITS+ZG).
    localparam real ATAN_SCALE = (2.0 ** (ANGLE_BITS + ZG)) / PI_R;

    typedef struct packed {
        logic signed [ANGLE_BITS-1:0] yaw_angle;
        logic signed [ANGLE_BITS-1:0] pitch_angle;
        logic signed [ANGLE_BITS-1:0] roll_angle;
    } in_t;

    typedef struct packed {
        logic signed [QW-1:0] quat_w;
        logic signed [QW-1:0] quat_x;
        logic signed [QW-1:0] quat_y;
        logic signed [QW-1:0] quat_z;
    } out_t;

    // atan(2^-i) in units of pi / 2^(ANGLE_BITS+ZG).
    function automatic logic signed [ZW-1:0] atan_step(input int i);
        real a;
        a = $atan(2.0 ** (-i)) * ATAN_SCALE;
        return ZW'(longint'(a));
    endfunction

    // Inverse CORDIC gain over all rotation stages, in CF fraction bits.
    function automatic logic signed [CW-1:0] cordic_gain();
        real g;
        real p;
        p = 1.0;
        for (int i = 0; i < NSTG; i++) begin
            p = p * (1.0 + 2.0 ** (-2 * i));
        end
        g = $pow(p, -0.5);
        return CW'(longint'(g * (2.0 ** CF)));
    endfunction

endpackage

`default_nettype wire

### rtl/euler_to_quaternion.sv
// Top level: ZYX Euler angles to a unit quaternion, fully pipelined.
// Depends on e2q_pkg, e2q_sincos and euler_to_quaternion_defines.svh.
//
//   Channel   Handshake           Payload          Direction
//   -------   -----------------   --------------   ---------
//   input     start, busy         angles (in_t)    in
//   result    done (strobe)       quat (out_t)     out
//
// One item may enter in every clock cycle; busy is never raised.
// Each result appears on quat with done high once its item has passed the whole
// pipeline: the CORDIC rotation stages set most of that depth, then two
// multiply stages and a rounding stage follow.
// Reset clears only the valid bits that travel with the data.
// The receiver takes every result in the cycle it is shown.
`default_nettype none

module euler_to_quaternion
    import e2q_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire in_t  angles,
    output logic      done,
    output out_t      quat
);

`include "euler_to_quaternion_defines.svh"

    localparam int PW = 2 * QW;
    localparam int TW = 3 * QW;
    localparam int SW = TW + 1;
    localparam logic signed [SW-1:0] HALF_Q = SW'(1) <<< (2 * FRAC_BITS - 1);
    localparam logic signed [SW-1:0] LIM_P  = SW'(1) <<< FRAC_BITS;
    localparam logic signed [SW-1:0] LIM_N  = -LIM_P;
    localparam logic signed [QW-1:0] LIM_PQ = QW'(1) <<< FRAC_BITS;
    localparam logic signed [QW-1:0] LIM_NQ = -LIM_PQ;

    // Components in order w, x, y, z; x and z subtract their second term.
    localparam logic [3:0] SUB = 4'b1010;

    logic [LAT-1:0] vld_reg;

    logic signed [QW-1:0] sy, cy, sp, cp, sr, cr;

    logic signed [QW-1:0] op_a [0:3];
    logic signed [QW-1:0] op_b [0:3];
    logic signed [QW-1:0] op_c [0:3];
    logic signed [QW-1:0] op_d [0:3];
    logic signed [QW-1:0] op_e [0:3];
    logic signed [QW-1:0] op_f [0:3];

    logic signed [PW-1:0] p1_reg [0:3];
    logic signed [PW-1:0] p2_reg [0:3];
    logic signed [QW-1:0] c_reg  [0:3];
    logic signed [QW-1:0] f_reg  [0:3];
    logic signed [TW-1:0] t1_reg [0:3];
    logic signed [TW-1:0] t2_reg [0:3];
    logic signed [QW-1:0] q_next [0:3];
    logic signed [QW-1:0] q_reg  [0:3];

    // The pipeline never stalls, so a new item is always welcome.
    assign busy = 1'b0;

    // Valid bits run alongside the data through every stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LAT-2:0], start & ~busy};
        end
    end

    e2q_sincos u_yaw (
        .clk     (clk),
        .angle   (angles.yaw_angle),
        .sin_val (sy),
        .cos_val (cy)
    );

    e2q_sincos u_pitch (
        .clk     (clk),
        .angle   (angles.pitch_angle),
        .sin_val (sp),
        .cos_val (cp)
    );

    e2q_sincos u_roll (
        .clk     (clk),
        .angle   (angles.roll_angle),
        .sin_val (sr),
        .cos_val (cr)
    );

    // Each component is a*b*c plus or minus d*e*f.
    always_comb
    begin
        op_a[0] = cr; op_b[0] = cp; op_c[0] = cy; op_d[0] = sr; op_e[0] = sp; op_f[0] = sy;
        op_a[1] = sr; op_b[1] = cp; op_c[1] = cy; op_d[1] = cr; op_e[1] = sp; op_f[1] = sy;
        op_a[2] = cr; op_b[2] = sp; op_c[2] = cy; op_d[2] = sr; op_e[2] = cp; op_f[2] = sy;
        op_a[3] = cr; op_b[3] = cp; op_c[3] = sy; op_d[3] = sr; op_e[3] = sp; op_f[3] = cy;
    end

    for (genvar k = 0; k < 4; k++) begin : g_comp
        logic signed [SW-1:0] term2;
        logic signed [SW-1:0] sum;
        logic signed [SW-1:0] shifted;

        // First stage: the two pairwise products, third factors carried along.
        always_ff @(posedge clk)
        begin
            p1_reg[k] <= op_a[k] * op_b[k];
            p2_reg[k] <= op_d[k] * op_e[k];
            c_reg[k]  <= op_c[k];
            f_reg[k]  <= op_f[k];
        end

        // Second stage: the full triple products, exact.
        always_ff @(posedge clk)
        begin
            t1_reg[k] <= TW'(p1_reg[k]) * TW'(c_reg[k]);
            t2_reg[k] <= TW'(p2_reg[k]) * TW'(f_reg[k]);
        end

        // Third stage: add, round half up to FRAC_BITS, then saturate.
        always_comb
        begin
            term2   = SUB[k] ? -SW'(t2_reg[k]) : SW'(t2_reg[k]);
            sum     = SW'(t1_reg[k]) + term2 + HALF_Q;
            shifted = sum >>> (2 * FRAC_BITS);
            if (shifted > LIM_P)
            begin
                q_next[k] = LIM_PQ;
            end
            else if (shifted < LIM_N)
            begin
                q_next[k] = LIM_NQ;
            end
            else
            begin
                q_next[k] = shifted[QW-1:0];
            end
        end

        always_ff @(posedge clk)
        begin
            q_reg[k] <= q_next[k];
        end
    end

    assign done        = vld_reg[LAT-1];
    assign quat.quat_w = q_reg[0];
    assign quat.quat_x = q_reg[1];
    assign quat.quat_y = q_reg[2];
    assign quat.quat_z = q_reg[3];

    // Every accepted item yields a result after the full pipeline depth.
    `E2Q_ASSERT_DLY(a_latency, start && !busy, LAT, done, "result strobe missing")

    // The w and z components of a result never leave the unit-quaternion range.
    `E2Q_ASSERT_IMPL(a_range, done,
        quat.quat_w <= LIM_PQ && quat.quat_w >= LIM_NQ &&
        quat.quat_z <= LIM_PQ && quat.quat_z >= LIM_NQ, "component out of range")

    // Zero attitude gives the identity quaternion.
    `E2Q_ASSERT_DLY(a_identity,
        start && !busy && angles.yaw_angle == 0 && angles.pitch_angle == 0 &&
        angles.roll_angle == 0, LAT,
        quat.quat_w == LIM_PQ && quat.quat_x == 0 && quat.quat_y == 0 &&
        quat.quat_z == 0, "zero angles did not give identity")

endmodule

`default_nettype wire

### rtl/e2q_sincos.sv
// Pipelined CORDIC giving sine and cosine of half a binary angle, rounded.
// Depends on e2q_pkg for widths, stage count and constant functions.
`default_nettype none

module e2q_sincos
    import e2q_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic [ANGLE_BITS-1:0]  angle,
    output logic signed [QW-1:0]        sin_val,
    output logic signed [QW-1:0]        cos_val
);

    localparam int SH = CF - FRAC_BITS;
    localparam logic signed [CW-1:0] HALF = CW'(1) <<< (SH - 1);
    localparam logic signed [CW-1:0] GAIN = cordic_gain();

    logic signed [CW-1:0] x_reg [0:NSTG];
    logic signed [CW-1:0] y_reg [0:NSTG];
    logic signed [ZW-1:0] z_reg [0:NSTG];
    logic                 neg_reg [0:NSTG];

    logic                  neg;
    logic [ANGLE_BITS:0]   mag;
    logic signed [CW-1:0]  cos_rnd, sin_rnd, cos_sh, sin_sh;
    logic signed [QW-1:0]  cos_next, sin_next;
    logic signed [QW-1:0]  cos_reg, sin_reg;

    // Fold a negative angle onto its magnitude; the sign returns on the sine.
    always_comb
    begin
        neg = angle[ANGLE_BITS-1];
        if (neg)
        begin
            mag = (ANGLE_BITS+1)'(1) << ANGLE_BITS;
            mag = mag - {1'b0, angle};
        end
        else
        begin
            mag = {1'b0, angle};
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]   <= GAIN;
        y_reg[0]   <= '0;
        z_reg[0]   <= {1'b0, mag[ANGLE_BITS-1:0], {ZG{1'b0}}};
        neg_reg[0] <= neg;
    end

    for (genvar i = 0; i < NSTG; i++) begin : g_stage
        localparam logic signed [ZW-1:0] ATAN_I = atan_step(i);
        always_ff @(posedge clk)
        begin
            neg_reg[i+1] <= neg_reg[i];
            if (z_reg[i][ZW-1])
            begin
                x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] + ATAN_I;
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] - ATAN_I;
            end
        end
    end

    // Round half up; a value that dips below zero by residual error is zero.
    always_comb
    begin
        cos_rnd = x_reg[NSTG] + HALF;
        sin_rnd = y_reg[NSTG] + HALF;
        cos_sh  = cos_rnd >>> SH;
        sin_sh  = sin_rnd >>> SH;
        cos_next = cos_sh[CW-1] ? '0 : cos_sh[QW-1:0];
        sin_next = sin_sh[CW-1] ? '0 : sin_sh[QW-1:0];
        if (neg_reg[NSTG])
        begin
            sin_next = -sin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cos_reg <= cos_next;
        sin_reg <= sin_next;
    end

    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

endmodule

`default_nettype wire

### dv/euler_to_quaternion_tb.sv
// Self-checking testbench for euler_to_quaternion: ZYX Euler angles to a Q1.14 quaternion.
// Depends on e2q_pkg and the RTL. It predicts every result with a bit-exact Taylor-series
// model and compares each done strobe against the oldest prediction.
`default_nettype none

module euler_to_quaternion_tb
    import e2q_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // pi * 2^61, the fixed-point scale used for the angle-to-radian step.
    localparam logic [63:0] PI_Q61 = 64'h6487ED5110B4611A;
    localparam int WATCHDOG_LIMIT = 4000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    in_t  angles;
    logic done;
    out_t quat;

    // Predicted quaternions, oldest first.
    out_t quat_expected[$];
    int   error_count;
    int   idle_cycles;

    euler_to_quaternion u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .angles (angles),
        .done   (done),
        .quat   (quat)
    );

    always #10 clk = ~clk;

    // Q2.62 multiply with truncation of the low bits.
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = {64'b0, a} * {64'b0, b};
        return prod[125:62];
    endfunction

    // Sine and cosine of half the binary angle, rounded to Q1.14.
    task automatic half_sincos(input logic [15:0] raw, output logic signed [15:0] s,
                               output logic signed [15:0] c);
        logic         neg;
        logic [16:0]  mag;
        logic [127:0] prod;
        logic [63:0]  x, x2, ts, tc, rs, rc;
        logic signed [63:0] ss, cs;
        neg  = raw[15];
        mag  = neg ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
        prod = {111'b0, mag} * {64'b0, PI_Q61};
        x    = prod[78:15];
        x2   = mul_q62(x, x);
        ts   = x;
        tc   = 64'd1 << 62;
        ss   = $signed(x);
        cs   = $signed(tc);
        for (int k = 1; k <= 15; k++)
        begin
            ts = mul_q62(ts, x2) / 64'((2 * k) * (2 * k + 1));
            tc = mul_q62(tc, x2) / 64'((2 * k - 1) * (2 * k));
            if (k % 2 == 1)
            begin
                ss = ss - $signed(ts);
                cs = cs - $signed(tc);
            end
            else
            begin
                ss = ss + $signed(ts);
                cs = cs + $signed(tc);
            end
        end
        // Rounding error can push the cosine just under zero near half angle -pi/2.
        if (ss < 0) ss = 0;
        if (cs < 0) cs = 0;
        rs = (64'(ss) + (64'd1 << 47)) >> 48;
        rc = (64'(cs) + (64'd1 << 47)) >> 48;
        s  = neg ? -$signed(rs[15:0]) : $signed(rs[15:0]);
        c  = $signed(rc[15:0]);
    endtask

    // a*b*c +/- d*e*f at full precision, rounded half up to Q1.14, clamped to +/-1.0.
    function automatic logic signed [15:0] quat_term(
        input logic signed [15:0] a, input logic signed [15:0] b, input logic signed [15:0] c,
        input logic signed [15:0] d, input logic signed [15:0] e, input logic signed [15:0] f,
        input logic subtract);
        logic signed [127:0] t1, t2, total;
        t1 = 128'(a) * 128'(b) * 128'(c);
        t2 = 128'(d) * 128'(e) * 128'(f);
        total = (subtract ? t1 - t2 : t1 + t2) + (128'sd1 <<< 27);
        total = total >>> 28;
        if (total > 128'sd16384) total = 128'sd16384;
        if (total < -128'sd16384) total = -128'sd16384;
        return total[15:0];
    endfunction

    task automatic predict_quat(input in_t item, output out_t q);
        logic signed [15:0] sy, cy, sp, cp, sr, cr;
        half_sincos(item.yaw_angle, sy, cy);
        half_sincos(item.pitch_angle, sp, cp);
        half_sincos(item.roll_angle, sr, cr);
        q.quat_w = quat_term(cr, cp, cy, sr, sp, sy, 1'b0);
        q.quat_x = quat_term(sr, cp, cy, cr, sp, sy, 1'b1);
        q.quat_y = quat_term(cr, sp, cy, sr, cp, sy, 1'b0);
        q.quat_z = quat_term(cr, cp, sy, sr, sp, cy, 1'b1);
    endtask

    // Mostly back-to-back or short gaps, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Presents one item, waits for it to be taken, records its prediction, then idles for the gap, if any.
    task automatic send_angles(input in_t item, input int gap);
        out_t q;
        start  <= 1'b1;
        angles <= item;
        do
            @(posedge clk);
        while (busy);
        predict_quat(item, q);
        quat_expected.push_back(q);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [15:0] random_angle();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h8001;
            3: return 16'($urandom_range(0, 15)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    // Field extremes, the most negative angle (sine -1, cosine 0) and its neighbor,
    // where the cosine series can dip below zero.
    task automatic test_extremes();
        logic [15:0] corner[6];
        corner = '{16'h8000, 16'h7FFF, 16'h0000, 16'h8001, 16'h0001, 16'hFFFF};
        for (int i = 0; i < 6; i++)
            send_angles('{corner[i], corner[(i + 1) % 6], corner[(i + 3) % 6]}, pick_gap());
        send_angles('{16'h8000, 16'h8000, 16'h8000}, 0);
        send_angles('{16'h7FFF, 16'h7FFF, 16'h7FFF}, 0);
        send_angles('{16'h0000, 16'h0000, 16'h0000}, pick_gap());
    endtask

    // Single-axis quarter turns both ways, plus gimbal lock at pitch of plus or minus pi/2.
    task automatic test_axes();
        send_angles('{16'h4000, 16'h0000, 16'h0000}, 0);
        send_angles('{16'h0000, 16'h4000, 16'h0000}, 0);
        send_angles('{16'h0000, 16'h0000, 16'h4000}, 0);
        send_angles('{16'hC000, 16'h0000, 16'h0000}, pick_gap());
        send_angles('{16'h0000, 16'hC000, 16'h0000}, 0);
        send_angles('{16'h0000, 16'h0000, 16'hC000}, 0);
        send_angles('{16'h2000, 16'h4000, 16'h2000}, pick_gap());
        send_angles('{16'h2000, 16'hC000, 16'hE000}, 0);
        send_angles('{16'h1555, 16'h1555, 16'h1555}, pick_gap());
    endtask

    task automatic test_random(input int count);
        for (int n = 0; n < count; n++)
        begin
            // A few stretches run with no idling at all.
            if ((n / 100) % 3 == 2)
                send_angles('{random_angle(), random_angle(), random_angle()}, 0);
            else
                send_angles('{random_angle(), random_angle(), random_angle()}, pick_gap());
        end
    endtask

    // Every strobe is taken; compare it against the oldest prediction.
    always @(posedge clk)
    begin
        out_t q;
        if (rst_n && done)
        begin
            if (quat_expected.size() == 0)
            begin
                $display("%0t: unexpected result, actual %h", $time, quat);
                error_count++;
            end
            else
            begin
                q = quat_expected.pop_front();
                if (quat.quat_w !== q.quat_w)
                begin
                    $display("%0t: quat_w expected %0d actual %0d", $time, q.quat_w, quat.quat_w);
                    error_count++;
                end
                if (quat.quat_x !== q.quat_x)
                begin
                    $display("%0t: quat_x expected %0d actual %0d", $time, q.quat_x, quat.quat_x);
                    error_count++;
                end
                if (quat.quat_y !== q.quat_y)
                begin
                    $display("%0t: quat_y expected %0d actual %0d", $time, q.quat_y, quat.quat_y);
                    error_count++;
                end
                if (quat.quat_z !== q.quat_z)
                begin
                    $display("%0t: quat_z expected %0d actual %0d", $time, q.quat_z, quat.quat_z);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither an item nor a result moves.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, quat_expected.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        angles      = '0;
        error_count = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_axes();
        test_random(1030);
        start <= 1'b0;

        // Drain the pipeline, then watch a little longer for stray strobes.
        while (quat_expected.size() != 0)
            @(posedge clk);
        repeat (LAT + 10) @(posedge clk);

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
